FILE: src/assert_macros.svh
// Assertion macros shared by the decoder modules.
// Depends on clk_i and rst_ni being visible in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define LZD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("decoder assertion failed");

// Same check with a caller supplied message.
`define LZD_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`endif

FILE: src/lzd_pkg.sv
// Package for the packet stream decoder: constants, codes and the
// command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package lzd_pkg;

  localparam int WINDOW_DEPTH = 4096;
  localparam int AW           = $clog2(WINDOW_DEPTH);
  localparam int FW           = AW + 1;
  localparam logic [16:0] POS_MAX = 17'h1FFFF;

  localparam logic [1:0] STAT_END   = 2'd0;
  localparam logic [1:0] STAT_TRUNC = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  typedef enum logic [1:0] {
    EM_NONE,
    EM_LIT,
    EM_COPY,
    EM_STAT
  } emit_e;

  typedef struct packed {
    logic       take_in;
    logic       hold_lo;
    logic       set_pend_hdr;
    logic       set_pend_abs;
    logic       set_cnt;
    logic       load_flags;
    logic       load_lit8;
    logic       dec_lit;
    logic       finish;
    logic       start_copy;
    logic       rd_issue;
    logic       copy_step;
    emit_e      emit;
    logic       emit_last;
    logic [1:0] stat_code;
  } cmd_t;

  typedef struct packed {
    logic pos_eq;
    logic byte_zero;
    logic cnt_zero;
    logic flag0;
    logic fin_zero;
    logic lit_one;
    logic off_bad;
    logic copy_last;
    logic out_free;
    logic last_in;
  } stat_t;

endpackage

FILE: src/lzd_if.sv
// Stream interfaces for compressed input and decoded output transfers.
// Depends on nothing.
`timescale 1ns / 1ps

interface lzd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, in_byte, in_last, input ready);
  modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface lzd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        is_status;
  logic [1:0]  status;
  logic [16:0] consumed;
  logic        out_last;
  modport source (output valid, out_byte, is_status, status, consumed, out_last,
                  input ready);
  modport sink   (input valid, out_byte, is_status, status, consumed, out_last,
                  output ready);
endinterface

FILE: src/lzd_ctrl.sv
// Controller of the decoder: stream phase and per-byte sequencing.
// Depends on lzd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lzd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lzd_pkg::stat_t st_i,
  output lzd_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {S_IDLE, S_EVAL, S_RD, S_WR, S_TAIL} state_e;
  typedef enum logic [3:0] {
    P_HDR_LO, P_HDR_HI, P_TOP, P_END_LO, P_END_HI, P_LIT8, P_ITEM, P_WORD_HI, P_DONE
  } phase_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state, next phase and datapath commands.
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cmd_o   = '0;
    cmd_o.emit = lzd_pkg::EM_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take_in = 1'b1;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        state_d = S_TAIL;
        unique case (phase_q)
          P_HDR_LO: begin
            cmd_o.hold_lo = 1'b1;
            phase_d = P_HDR_HI;
          end
          P_HDR_HI: begin
            cmd_o.set_pend_hdr = 1'b1;
            phase_d = P_TOP;
          end
          P_TOP: begin
            if (st_i.pos_eq) begin
              if (st_i.cnt_zero) begin
                if (st_i.out_free) begin
                  cmd_o.emit      = lzd_pkg::EM_STAT;
                  cmd_o.stat_code = lzd_pkg::STAT_END;
                  cmd_o.emit_last = 1'b1;
                  phase_d = P_DONE;
                end else begin
                  state_d = S_EVAL;
                end
              end else begin
                cmd_o.set_cnt = 1'b1;
                phase_d = P_END_LO;
              end
            end else if (st_i.byte_zero) begin
              cmd_o.load_lit8 = 1'b1;
              phase_d = P_LIT8;
            end else begin
              cmd_o.load_flags = 1'b1;
              phase_d = P_ITEM;
            end
          end
          P_END_LO: begin
            cmd_o.hold_lo = 1'b1;
            phase_d = P_END_HI;
          end
          P_END_HI: begin
            cmd_o.set_pend_abs = 1'b1;
            phase_d = P_TOP;
          end
          P_LIT8: begin
            if (st_i.out_free) begin
              cmd_o.emit      = lzd_pkg::EM_LIT;
              cmd_o.emit_last = !st_i.last_in;
              cmd_o.dec_lit   = 1'b1;
              if (st_i.lit_one) phase_d = P_TOP;
            end else begin
              state_d = S_EVAL;
            end
          end
          P_ITEM: begin
            if (st_i.flag0) begin
              cmd_o.hold_lo = 1'b1;
              phase_d = P_WORD_HI;
            end else if (st_i.out_free) begin
              cmd_o.emit      = lzd_pkg::EM_LIT;
              cmd_o.emit_last = !st_i.last_in;
              cmd_o.finish    = 1'b1;
              phase_d = st_i.fin_zero ? P_TOP : P_ITEM;
            end else begin
              state_d = S_EVAL;
            end
          end
          P_WORD_HI: begin
            if (st_i.off_bad) begin
              if (st_i.out_free) begin
                cmd_o.emit      = lzd_pkg::EM_STAT;
                cmd_o.stat_code = lzd_pkg::STAT_RANGE;
                cmd_o.emit_last = 1'b1;
                phase_d = P_DONE;
              end else begin
                state_d = S_EVAL;
              end
            end else begin
              cmd_o.start_copy = 1'b1;
              state_d = S_RD;
            end
          end
          default: begin
            // Finished stream: the byte is dropped.
            phase_d = P_DONE;
            state_d = S_IDLE;
          end
        endcase
      end
      S_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d = S_WR;
      end
      S_WR: begin
        if (st_i.out_free) begin
          cmd_o.emit      = lzd_pkg::EM_COPY;
          cmd_o.emit_last = st_i.copy_last && !st_i.last_in;
          cmd_o.copy_step = 1'b1;
          if (st_i.copy_last) begin
            cmd_o.finish = 1'b1;
            phase_d = st_i.fin_zero ? P_TOP : P_ITEM;
            state_d = S_TAIL;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_TAIL: begin
        // A last input byte on an open stream reports truncation.
        if (st_i.last_in && phase_q != P_DONE) begin
          if (st_i.out_free) begin
            cmd_o.emit      = lzd_pkg::EM_STAT;
            cmd_o.stat_code = lzd_pkg::STAT_TRUNC;
            cmd_o.emit_last = 1'b1;
            phase_d = P_DONE;
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and phase registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= P_HDR_LO;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  // A copy byte is only emitted after its history read, once the output register is free.
  `LZD_ASSERT(a_wr_after_rd, (state_q == S_WR) |-> ($past(state_q) == S_RD || $past(state_q) == S_WR))
  // A finished stream never emits another result.
  `LZD_ASSERT_MSG(a_done_quiet, (phase_q == P_DONE) |-> (cmd_o.emit == lzd_pkg::EM_NONE), "emit after done")

endmodule

FILE: src/lzd_datapath.sv
// Datapath of the decoder: history memory, stream registers, output register.
// Depends on lzd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lzd_datapath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_data_i,
  input  logic [7:0]    in_byte_i,
  input  logic          in_last_i,
  input  lzd_pkg::cmd_t  cmd_i,
  output lzd_pkg::stat_t st_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output logic [7:0]    out_byte_o,
  output logic          is_status_o,
  output logic [1:0]    status_o,
  output logic [16:0]   consumed_o,
  output logic          out_last_o
);

  logic [7:0]  hist_q [lzd_pkg::WINDOW_DEPTH];
  logic [7:0]  rd_data_q;
  logic [7:0]  byte_q, hold_q, flags_q;
  logic        last_q, short_q;
  logic [lzd_pkg::AW-1:0] wp_q, off_q;
  logic [lzd_pkg::FW-1:0] fill_q;
  logic [16:0] pos_q, pos_at_q, pend_q;
  logic [5:0]  cnt_q, rem_q;
  logic [3:0]  lit_q;
  logic        out_valid_q;
  logic [7:0]  ob_q;
  logic        os_q, ol_q;
  logic [1:0]  oc_q;
  logic [16:0] ocons_q;

  logic [15:0] code;
  logic [11:0] off_w;
  logic [5:0]  len_w;
  logic [7:0]  emit_val;
  logic        emit_data;
  logic [5:0]  cnt_dec;

  // Match word decode under the current offset width.
  assign code  = {byte_q, hold_q};
  assign off_w = short_q ? {1'b0, code[10:0]} : code[11:0];
  assign len_w = short_q ? ({1'b0, code[15:11]} + 6'd3) : ({2'b00, code[15:12]} + 6'd3);

  assign emit_data = (cmd_i.emit == lzd_pkg::EM_LIT) || (cmd_i.emit == lzd_pkg::EM_COPY);
  assign emit_val  = (cmd_i.emit == lzd_pkg::EM_LIT) ? byte_q :
                     ((off_q == '0) ? 8'h00 : rd_data_q);
  assign cnt_dec   = cnt_q - 6'd1;

  // Status toward the controller.
  always_comb begin
    st_o.pos_eq    = (pos_at_q == pend_q);
    st_o.byte_zero = (byte_q == 8'h00);
    st_o.cnt_zero  = (byte_q[5:0] == 6'd0);
    st_o.flag0     = flags_q[0];
    st_o.fin_zero  = (cnt_dec == 6'd0);
    st_o.lit_one   = (lit_q == 4'd1);
    st_o.off_bad   = ({1'b0, off_w} > 13'(fill_q));
    st_o.copy_last = (rem_q == 6'd1);
    st_o.out_free  = !out_valid_q || out_ready_i;
    st_o.last_in   = last_q;
  end

  // History memory: one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (emit_data) hist_q[wp_q] <= emit_val;
    if (cmd_i.rd_issue) rd_data_q <= hist_q[wp_q - off_q];
  end

  // Payload registers without reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      byte_q <= in_byte_i;
      last_q <= in_last_i;
    end
    if (cmd_i.start_copy) begin
      off_q <= off_w[lzd_pkg::AW-1:0];
      rem_q <= len_w;
    end else if (cmd_i.copy_step) begin
      rem_q <= rem_q - 6'd1;
    end
    if (cmd_i.emit != lzd_pkg::EM_NONE) begin
      ob_q    <= (cmd_i.emit == lzd_pkg::EM_STAT) ? 8'h00 : emit_val;
      os_q    <= (cmd_i.emit == lzd_pkg::EM_STAT);
      oc_q    <= (cmd_i.emit == lzd_pkg::EM_STAT) ? cmd_i.stat_code : lzd_pkg::STAT_END;
      ocons_q <= (cmd_i.emit == lzd_pkg::EM_STAT && cmd_i.stat_code == lzd_pkg::STAT_END)
                 ? pos_q : 17'd0;
      ol_q    <= cmd_i.emit_last;
    end
  end

  // Stream state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_q     <= 1'b1;
      wp_q        <= '0;
      fill_q      <= '0;
      pos_q       <= '0;
      pos_at_q    <= '0;
      pend_q      <= '0;
      cnt_q       <= 6'd8;
      flags_q     <= '0;
      lit_q       <= '0;
      hold_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) short_q <= cfg_data_i;
      if (cmd_i.take_in) begin
        pos_at_q <= pos_q;
        if (pos_q != lzd_pkg::POS_MAX) pos_q <= pos_q + 17'd1;
      end
      if (cmd_i.hold_lo) hold_q <= byte_q;
      if (cmd_i.set_pend_hdr) pend_q <= {1'b0, byte_q, hold_q} + 17'd2;
      if (cmd_i.set_pend_abs) pend_q <= {1'b0, byte_q, hold_q};
      if (cmd_i.set_cnt) cnt_q <= byte_q[5:0];
      if (cmd_i.load_flags) flags_q <= byte_q;
      if (cmd_i.load_lit8) lit_q <= 4'd8;
      if (cmd_i.dec_lit) lit_q <= lit_q - 4'd1;
      if (cmd_i.finish) begin
        flags_q <= {1'b0, flags_q[7:1]};
        cnt_q   <= (cnt_dec == 6'd0) ? 6'd8 : cnt_dec;
      end
      if (emit_data) begin
        wp_q <= wp_q + 1'b1;
        if (fill_q != lzd_pkg::FW'(lzd_pkg::WINDOW_DEPTH)) fill_q <= fill_q + 1'b1;
      end
      if (cmd_i.emit != lzd_pkg::EM_NONE) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = ob_q;
  assign is_status_o = os_q;
  assign status_o    = oc_q;
  assign consumed_o  = ocons_q;
  assign out_last_o  = ol_q;

  // Results are only loaded when the output register can take them.
  `LZD_ASSERT(a_emit_free, (cmd_i.emit != lzd_pkg::EM_NONE) |-> st_o.out_free)
  // The fill count never passes the window size.
  `LZD_ASSERT(a_fill_max, fill_q <= lzd_pkg::FW'(lzd_pkg::WINDOW_DEPTH))

endmodule

FILE: src/lz_packet_stream_decoder.sv
// Packet stream decoder top level. A literal byte is registered on its transfer
// and then loaded into the output register once that is free. A match word's
// high byte is registered and starts a copy; each copied byte is read from the
// history memory's single read port and then written out (S_RD, then S_WR).
// A new input byte is taken only in S_IDLE, after the last one is through.
// Reset clears all control state; history contents stay undefined.
`timescale 1ns / 1ps

module lz_packet_stream_decoder (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic     cfg_data_i,
  lzd_in_if.sink   in_i,
  lzd_out_if.source out_o
);

  lzd_pkg::cmd_t  cmd;
  lzd_pkg::stat_t st;

  // Sequencing of phases and copies.
  lzd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // Storage, arithmetic and result register.
  lzd_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_byte_i   (in_i.in_byte),
    .in_last_i   (in_i.in_last),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_byte_o  (out_o.out_byte),
    .is_status_o (out_o.is_status),
    .status_o    (out_o.status),
    .consumed_o  (out_o.consumed),
    .out_last_o  (out_o.out_last)
  );

endmodule
